### rtl/core/nack_retry_backoff_table_top_assert.svh
// Assertion macros for the NACK backoff table top level.
// Both sample on clk and are off while arst_n is low.
`ifndef NACK_RETRY_BACKOFF_TABLE_TOP_ASSERT_SVH
`define NACK_RETRY_BACKOFF_TABLE_TOP_ASSERT_SVH

// Same-cycle implication
`define NRBT_CHECK_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nrbt same-cycle check failed");

// Next-cycle implication
`define NRBT_CHECK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nrbt next-cycle check failed");

`endif

### rtl/core/nrbt_pkg.sv
package nrbt_pkg;

	localparam int SEQ_W  = 16;
	localparam int TIME_W = 32;
	localparam int RET_W  = 4;
	localparam int RTT_W  = 14;
	localparam int CFG_AW = 1;
	localparam int CFG_DW = RTT_W;

	localparam int DEFAULT_DEPTH = 64;

	localparam logic [RTT_W-1:0] RTT_RST  = RTT_W'(100);
	localparam logic [RET_W-1:0] MAXR_RST = RET_W'(5);
	localparam logic [RET_W-1:0] RET_MAX  = '1;

	typedef enum logic [CFG_AW-1:0] {
		CFG_RTT = 1'b0,
		CFG_MAX = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		REQ_QUERY  = 2'd0,
		REQ_RECORD = 2'd1,
		REQ_CLEAR  = 2'd2,
		REQ_SCAN   = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		K_ANSWER = 2'd0,
		K_ACK    = 2'd1,
		K_NACK   = 2'd2,
		K_NONE   = 2'd3
	} rsp_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_POW,
		ST_NEXT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		req_kind_t          req_type;
		logic [SEQ_W-1:0]   seq;
		logic [TIME_W-1:0]  now_ms;
	} req_item_t;

	typedef struct packed {
		rsp_kind_t          kind;
		logic               permitted;
		logic [SEQ_W-1:0]   nack_seq;
		logic               last;
	} rsp_item_t;

	// One table slot; retries of zero means empty
	typedef struct packed {
		logic [SEQ_W-1:0]   seq;
		logic [RET_W-1:0]   retries;
		logic [TIME_W-1:0]  last_ms;
	} slot_t;

endpackage

### rtl/core/nack_retry_backoff_table_top.sv
// NACK retry tracker with exponential backoff over a direct-mapped slot table.
// Request channel (req_valid/req_ready/req_data): query, record, clear or scan.
// Response channel (rsp_valid/rsp_ready/rsp_data): one beat per query, record
// or clear; a scan gives one beat per due slot (last set on the final one) or
// a single "nothing due" beat. cfg_we/cfg_addr/cfg_wdata write rtt_ms and
// max_retries, to be used only while the block is idle.
// For record, clear and queries that need no backoff, the sequencer reads the
// slot, evaluates it and loads the beat into the output register; a query on
// a live slot below max_retries first raises rtt_ms to its retry count in the
// shared power multiplier. A scan walks all TABLE_DEPTH slots, reading and
// evaluating each and running the multiplier for each such live slot.
// One request is in work at a time; req_ready is high only when the sequencer
// is idle. The response sits in an output register, so the next request is
// taken while it waits; a stalled receiver holds the sequencer only when a
// new beat has to be loaded.
// Reset empties the table at once through per-slot written marks (no clearing
// pass) and loads rtt_ms = 100, max_retries = 5.
module nack_retry_backoff_table_top
	import nrbt_pkg::*;
#(
	parameter int TABLE_DEPTH = DEFAULT_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_AW-1:0]    cfg_addr,
	input  logic [CFG_DW-1:0]    cfg_wdata,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  req_item_t            req_data,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output rsp_item_t            rsp_data
);

	localparam int IDX_W  = $clog2(TABLE_DEPTH);
	// exact seq / TABLE_DEPTH by reciprocal multiply
	localparam int MOD_S  = SEQ_W + IDX_W;
	localparam int MOD_MW = SEQ_W + 1;
	localparam int PROD_W = SEQ_W + MOD_MW;
	localparam logic [MOD_MW-1:0] MOD_M =
		MOD_MW'((2 ** MOD_S + TABLE_DEPTH - 1) / TABLE_DEPTH);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

	state_t             state_q, state_d;
	req_kind_t          req_q;
	logic [SEQ_W-1:0]   seq_q;
	logic [TIME_W-1:0]  now_q;
	logic [SEQ_W-1:0]   quo_q;
	logic [IDX_W-1:0]   idx_q;
	rsp_item_t          res_q, res_d;
	logic               pend_vld_q;
	logic [SEQ_W-1:0]   pend_seq_q;
	rsp_item_t          out_q;
	logic               out_valid_q;
	logic [RTT_W-1:0]   rtt_q;
	logic [RET_W-1:0]   maxr_q;

	logic [PROD_W-1:0]    quo_prod;
	logic [PROD_W-1:0]    quo_full;
	logic [2*SEQ_W-1:0]   quo_back;
	logic [SEQ_W-1:0]     rem;
	logic [IDX_W-1:0]     slot_addr;
	slot_t                slot;
	slot_t                wr_slot;
	logic                 rd_en, wr_en;
	logic                 pow_start, pow_done;
	logic [TIME_W-1:0]    pow_wait;
	logic [TIME_W-1:0]    elapsed;
	logic                 owned, exhausted, due;
	logic [RET_W-1:0]     ret_inc;
	logic                 res_ld, pend_set, pend_clr, idx_inc, out_ld, out_free;
	logic                 accept;

	assign accept = req_valid && req_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rtt_q  <= RTT_RST;
			maxr_q <= MAXR_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				CFG_RTT: rtt_q  <= cfg_wdata;
				CFG_MAX: maxr_q <= cfg_wdata[RET_W-1:0];
			endcase
		end
	end

	// slot index = seq mod depth; quotient registered at accept
	assign quo_prod  = PROD_W'(req_data.seq) * PROD_W'(MOD_M);
	assign quo_full  = quo_prod >> MOD_S;
	assign quo_back  = (2*SEQ_W)'(quo_q) * (2*SEQ_W)'(TABLE_DEPTH);
	assign rem       = seq_q - quo_back[SEQ_W-1:0];
	assign slot_addr = (req_q == REQ_SCAN) ? idx_q : rem[IDX_W-1:0];

	nrbt_table #(
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (slot_addr),
		.rd_slot (slot),
		.wr_en   (wr_en),
		.wr_addr (slot_addr),
		.wr_slot (wr_slot)
	);

	nrbt_pow u_pow (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (pow_start),
		.pw_exp  (slot.retries),
		.pw_base (rtt_q),
		.done    (pow_done),
		.result  (pow_wait)
	);

	// slot checks
	assign owned     = (slot.seq == seq_q) && (slot.retries != '0);
	assign exhausted = slot.retries >= maxr_q;
	assign elapsed   = now_q - slot.last_ms;
	assign due       = elapsed >= pow_wait;
	assign ret_inc   = (slot.retries == RET_MAX) ? RET_MAX : slot.retries + 1'b1;
	assign out_free  = !out_valid_q || rsp_ready;

	// sequencer
	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		rd_en     = 1'b0;
		wr_en     = 1'b0;
		wr_slot   = '0;
		pow_start = 1'b0;
		res_ld    = 1'b0;
		res_d     = '0;
		pend_set  = 1'b0;
		pend_clr  = 1'b0;
		idx_inc   = 1'b0;
		out_ld    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				rd_en   = 1'b1;
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				unique case (req_q)
					REQ_QUERY: begin
						if (!owned || exhausted) begin
							res_ld  = 1'b1;
							res_d   = '{kind: K_ANSWER, permitted: !owned,
								nack_seq: '0, last: 1'b1};
							state_d = ST_EMIT;
						end else begin
							pow_start = 1'b1;
							state_d   = ST_POW;
						end
					end
					REQ_RECORD: begin
						wr_en   = 1'b1;
						wr_slot = owned ? '{seq: slot.seq, retries: ret_inc, last_ms: now_q}
							: '{seq: seq_q, retries: RET_W'(1), last_ms: now_q};
						res_ld  = 1'b1;
						res_d   = '{kind: K_ACK, permitted: 1'b0, nack_seq: '0, last: 1'b1};
						state_d = ST_EMIT;
					end
					REQ_CLEAR: begin
						wr_en   = (slot.seq == seq_q);
						res_ld  = 1'b1;
						res_d   = '{kind: K_ACK, permitted: 1'b0, nack_seq: '0, last: 1'b1};
						state_d = ST_EMIT;
					end
					REQ_SCAN: begin
						if (slot.retries == '0) begin
							state_d = ST_NEXT;
						end else if (exhausted) begin
							// drop the slot, stamp left as is
							wr_en   = 1'b1;
							wr_slot = '{seq: '0, retries: '0, last_ms: slot.last_ms};
							state_d = ST_NEXT;
						end else begin
							pow_start = 1'b1;
							state_d   = ST_POW;
						end
					end
				endcase
			end
			ST_POW: begin
				if (pow_done) begin
					if (req_q == REQ_QUERY) begin
						res_ld  = 1'b1;
						res_d   = '{kind: K_ANSWER, permitted: due, nack_seq: '0, last: 1'b1};
						state_d = ST_EMIT;
					end else if (due) begin
						wr_en    = 1'b1;
						wr_slot  = '{seq: slot.seq, retries: ret_inc, last_ms: now_q};
						pend_set = 1'b1;
						// previous NACK is not the last one; send it now
						if (pend_vld_q) begin
							res_ld  = 1'b1;
							res_d   = '{kind: K_NACK, permitted: 1'b0,
								nack_seq: pend_seq_q, last: 1'b0};
							state_d = ST_EMIT;
						end else begin
							state_d = ST_NEXT;
						end
					end else begin
						state_d = ST_NEXT;
					end
				end
			end
			ST_NEXT: begin
				if (idx_q == IDX_LAST) begin
					res_ld   = 1'b1;
					pend_clr = 1'b1;
					res_d    = pend_vld_q
						? '{kind: K_NACK, permitted: 1'b0, nack_seq: pend_seq_q, last: 1'b1}
						: '{kind: K_NONE, permitted: 1'b0, nack_seq: '0, last: 1'b1};
					state_d  = ST_EMIT;
				end else begin
					idx_inc = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					out_ld  = 1'b1;
					state_d = res_q.last ? ST_IDLE : ST_NEXT;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			req_q       <= REQ_QUERY;
			idx_q       <= '0;
			pend_vld_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				req_q <= req_data.req_type;
				idx_q <= '0;
			end else if (idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (pend_set) begin
				pend_vld_q <= 1'b1;
			end else if (pend_clr) begin
				pend_vld_q <= 1'b0;
			end
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			seq_q <= req_data.seq;
			now_q <= req_data.now_ms;
			quo_q <= quo_full[SEQ_W-1:0];
		end
		if (res_ld) begin
			res_q <= res_d;
		end
		if (pend_set) begin
			pend_seq_q <= slot.seq;
		end
		if (out_ld) begin
			out_q <= res_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

	`include "nack_retry_backoff_table_top_assert.svh"

	`NRBT_CHECK_NOW(a_pow_in_pow_state, pow_done, state_q == ST_POW)
	`NRBT_CHECK_NOW(a_no_beat_overwrite, out_ld, out_free)
	`NRBT_CHECK_NOW(a_no_stale_pending, accept, !pend_vld_q)
	`NRBT_CHECK_NEXT(a_accept_reads, accept, state_q == ST_READ)

endmodule

### rtl/core/nrbt_table.sv
module nrbt_table
	import nrbt_pkg::*;
#(
	parameter int DEPTH = DEFAULT_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [$clog2(DEPTH)-1:0]   rd_addr,
	output slot_t                      rd_slot,
	input  logic                       wr_en,
	input  logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  slot_t                      wr_slot
);

	slot_t              mem [DEPTH];
	logic [DEPTH-1:0]   vld_q;
	slot_t              rd_slot_q;
	logic               rd_vld_q;

	// slot storage, one write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_slot;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_slot_q <= mem[rd_addr];
		end
	end

	// per-slot written marks; an unwritten slot reads as all zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_slot = rd_vld_q ? rd_slot_q : '0;

endmodule

### rtl/core/nrbt_pow.sv
module nrbt_pow
	import nrbt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [RET_W-1:0]     pw_exp,
	input  logic [RTT_W-1:0]     pw_base,
	output logic                 done,
	output logic [TIME_W-1:0]    result
);

	localparam int PROD_W = TIME_W + RTT_W;

	logic [TIME_W-1:0]  acc_q;
	logic [RET_W-1:0]   cnt_q;
	logic               run_q;
	logic [PROD_W-1:0]  prod;
	logic [TIME_W-1:0]  prod_sat;

	// one multiply per cycle, clamped to all ones
	assign prod     = PROD_W'(acc_q) * PROD_W'(pw_base);
	assign prod_sat = (|prod[PROD_W-1:TIME_W]) ? '1 : prod[TIME_W-1:0];

	// accumulator; exponent zero gives a wait of zero
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= (pw_exp == '0) ? '0 : TIME_W'(1);
		end else if (run_q && (cnt_q != '0)) begin
			acc_q <= prod_sat;
		end
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			run_q <= 1'b0;
		end else if (start) begin
			cnt_q <= pw_exp;
			run_q <= 1'b1;
		end else if (run_q) begin
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end else begin
				run_q <= 1'b0;
			end
		end
	end

	assign done   = run_q && (cnt_q == '0);
	assign result = acc_q;

endmodule

### dv/tb.sv
module tb;
	import nrbt_pkg::*;

	localparam int TABLE_DEPTH = DEFAULT_DEPTH;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam logic [63:0] POW_SAT = 64'hFFFF_FFFF;

	typedef struct {
		req_item_t item;
		bit        hold;
	} pend_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cfg_we    = 1'b0;
	logic [CFG_AW-1:0] cfg_addr  = '0;
	logic [CFG_DW-1:0] cfg_wdata = '0;
	logic              req_valid = 1'b0;
	logic              req_ready;
	req_item_t         req_data  = '0;
	logic              rsp_valid;
	logic              rsp_ready = 1'b0;
	rsp_item_t         rsp_data;

	// shadow copy of the slot table and the two registers
	slot_t            tbl_shadow[TABLE_DEPTH];
	logic [RTT_W-1:0] rtt_shadow;
	logic [RET_W-1:0] maxr_shadow;

	pend_t     req_backlog[$];
	rsp_item_t table_rsp_q[$];

	int                send_idle_pct = 0;
	int                recv_idle_pct = 0;
	int                err_cnt       = 0;
	int                cyc_cnt       = 0;
	logic [TIME_W-1:0] gen_ms;

	nack_retry_backoff_table_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// base^r, saturated to 32 bits; zero retries wait nothing
	function automatic logic [TIME_W-1:0] backoff_ms(logic [RTT_W-1:0] base,
			logic [RET_W-1:0] r);
		logic [63:0] acc;
		acc = 64'd1;
		if (r == '0)
			return '0;
		for (int k = 0; k < r; k++) begin
			acc = acc * base;
			if (acc > POW_SAT)
				acc = POW_SAT;
		end
		return acc[TIME_W-1:0];
	endfunction

	function automatic bit slot_due(slot_t s, logic [TIME_W-1:0] now);
		logic [TIME_W-1:0] elapsed;
		elapsed = now - s.last_ms;
		return elapsed >= backoff_ms(rtt_shadow, s.retries);
	endfunction

	function automatic logic [RET_W-1:0] bump_retries(logic [RET_W-1:0] r);
		return (r == RET_MAX) ? RET_MAX : r + 1'b1;
	endfunction

	// apply one request to the shadow table and queue the beats it yields
	task automatic table_step(req_item_t it);
		int idx;
		int n_nack;
		bit ok;
		idx    = it.seq % TABLE_DEPTH;
		n_nack = 0;
		case (it.req_type)
		REQ_QUERY: begin
			if (tbl_shadow[idx].seq != it.seq || tbl_shadow[idx].retries == '0)
				ok = 1'b1;
			else if (tbl_shadow[idx].retries >= maxr_shadow)
				ok = 1'b0;
			else
				ok = slot_due(tbl_shadow[idx], it.now_ms);
			table_rsp_q.push_back(rsp_item_t'{K_ANSWER, ok, 16'd0, 1'b1});
		end
		REQ_RECORD: begin
			if (tbl_shadow[idx].seq != it.seq || tbl_shadow[idx].retries == '0) begin
				tbl_shadow[idx].seq     = it.seq;
				tbl_shadow[idx].retries = RET_W'(1);
			end else begin
				tbl_shadow[idx].retries = bump_retries(tbl_shadow[idx].retries);
			end
			tbl_shadow[idx].last_ms = it.now_ms;
			table_rsp_q.push_back(rsp_item_t'{K_ACK, 1'b0, 16'd0, 1'b1});
		end
		REQ_CLEAR: begin
			// only a matching slot is emptied, an empty slot 0 included
			if (tbl_shadow[idx].seq == it.seq)
				tbl_shadow[idx] = '0;
			table_rsp_q.push_back(rsp_item_t'{K_ACK, 1'b0, 16'd0, 1'b1});
		end
		default: begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				if (tbl_shadow[i].retries == '0)
					continue;
				// exhausted: drop, keep the time stamp
				if (tbl_shadow[i].retries >= maxr_shadow) begin
					tbl_shadow[i].seq     = '0;
					tbl_shadow[i].retries = '0;
					continue;
				end
				if (slot_due(tbl_shadow[i], it.now_ms)) begin
					table_rsp_q.push_back(rsp_item_t'{K_NACK, 1'b0, tbl_shadow[i].seq, 1'b0});
					n_nack++;
					tbl_shadow[i].retries = bump_retries(tbl_shadow[i].retries);
					tbl_shadow[i].last_ms = it.now_ms;
				end
			end
			if (n_nack == 0)
				table_rsp_q.push_back(rsp_item_t'{K_NONE, 1'b0, 16'd0, 1'b1});
			else
				table_rsp_q[table_rsp_q.size() - 1].last = 1'b1;
		end
		endcase
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_cnt++;
		end
	endtask

	task automatic push_req(req_kind_t kind, logic [SEQ_W-1:0] seq,
			logic [TIME_W-1:0] now, bit hold = 1'b0);
		req_backlog.push_back(pend_t'{req_item_t'{kind, seq, now}, hold});
	endtask

	// both registers, back to back, while the block is idle
	task automatic set_regs(logic [RTT_W-1:0] rtt, logic [RET_W-1:0] maxr);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= CFG_RTT;
		cfg_wdata <= rtt;
		rtt_shadow = rtt;
		@(posedge clk);
		cfg_addr  <= CFG_MAX;
		cfg_wdata <= CFG_DW'(maxr);
		maxr_shadow = maxr;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		while (req_backlog.size() != 0 || req_valid || table_rsp_q.size() != 0 || !req_ready)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// time offset near a backoff boundary for some retry count
	function automatic logic [TIME_W-1:0] near_wait(logic [RTT_W-1:0] rtt);
		logic [TIME_W-1:0] w;
		w = backoff_ms(rtt, RET_W'($urandom_range(0, 6)));
		case ($urandom_range(5))
		0:       return w - 1'b1;
		1, 2:    return w;
		3:       return w + 1'b1;
		4:       return $urandom_range(0, w);
		default: return '1;
		endcase
	endfunction

	// mostly record/query/scan/clear runs over a few colliding seqs, some noise
	task automatic gen_phase(int n_items, int psize, logic [RTT_W-1:0] rtt);
		logic [SEQ_W-1:0] pool[6];
		logic [SEQ_W-1:0] base;
		int               roll;
		req_item_t        it;
		base    = SEQ_W'($urandom);
		pool[0] = base;
		pool[1] = SEQ_W'($urandom);
		pool[2] = base + SEQ_W'(TABLE_DEPTH);
		pool[3] = base + SEQ_W'(2 * TABLE_DEPTH);
		pool[4] = SEQ_W'($urandom);
		pool[5] = SEQ_W'($urandom);
		for (int n = 0; n < n_items; n++) begin
			roll = $urandom_range(99);
			if (roll < 10) begin
				it.req_type = req_kind_t'($urandom_range(3));
				it.seq      = SEQ_W'($urandom);
				it.now_ms   = $urandom;
			end else begin
				it.seq = pool[$urandom_range(psize - 1)];
				roll   = $urandom_range(99);
				if (roll < 32) begin
					it.req_type = REQ_RECORD;
					gen_ms      = gen_ms + near_wait(rtt);
					it.now_ms   = gen_ms;
				end else begin
					if (roll < 62)
						it.req_type = REQ_QUERY;
					else if (roll < 87)
						it.req_type = REQ_SCAN;
					else
						it.req_type = REQ_CLEAR;
					it.now_ms = gen_ms + near_wait(rtt);
				end
			end
			req_backlog.push_back(pend_t'{it, n == n_items / 2 || $urandom_range(99) < 3});
		end
	endtask

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready)
				table_step(req_data);
			if (!req_valid || req_ready) begin
				if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct
						&& !(req_backlog[0].hold && table_rsp_q.size() != 0)) begin
					req_data  <= req_backlog[0].item;
					req_valid <= 1'b1;
					void'(req_backlog.pop_front());
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// response monitor and receiver stalls
	always @(posedge clk) begin
		rsp_item_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (table_rsp_q.size() == 0) begin
					$error("response beat with nothing outstanding: kind %0d nack_seq %0d",
						rsp_data.kind, rsp_data.nack_seq);
					err_cnt++;
				end else begin
					want = table_rsp_q.pop_front();
					check_field("kind", want.kind, rsp_data.kind);
					check_field("permitted", want.permitted, rsp_data.permitted);
					check_field("nack_seq", want.nack_seq, rsp_data.nack_seq);
					check_field("last", want.last, rsp_data.last);
				end
			end
			rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cyc_cnt <= cyc_cnt + 1;
		if (cyc_cnt >= CYCLE_LIMIT) begin
			$display("nack_retry_backoff_table_top regression: fail");
			$finish;
		end
	end

	initial begin
		logic [RTT_W-1:0] rtt_pick;
		logic [RET_W-1:0] maxr_pick;
		int               psize;
		int               n_items;
		for (int i = 0; i < TABLE_DEPTH; i++)
			tbl_shadow[i] = '0;
		rtt_shadow    = RTT_RST;
		maxr_shadow   = MAXR_RST;
		gen_ms        = $urandom;
		send_idle_pct = 28;
		recv_idle_pct = 67;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: waits 3 and 9 with give-up at 3 retries
		set_regs(14'd3, 4'd3);
		push_req(REQ_QUERY, 16'd0, 32'd0);
		push_req(REQ_CLEAR, 16'd0, 32'd0);
		push_req(REQ_SCAN, 16'd0, 32'd0);
		push_req(REQ_RECORD, 16'd5, 32'd1000);
		push_req(REQ_QUERY, 16'd5, 32'd1002);
		push_req(REQ_QUERY, 16'd5, 32'd1003);
		push_req(REQ_QUERY, 16'd69, 32'd1000);
		push_req(REQ_RECORD, 16'd5, 32'd1003);
		push_req(REQ_SCAN, 16'd0, 32'd1011);
		push_req(REQ_SCAN, 16'd0, 32'd1012);
		push_req(REQ_QUERY, 16'd5, 32'd5000);
		push_req(REQ_SCAN, 16'hFFFF, 32'd5000, 1'b1);
		// time wraps between stamp and scan; three nacks in one scan
		push_req(REQ_RECORD, 16'hFFFF, 32'hFFFF_FFFE);
		push_req(REQ_RECORD, 16'd64, 32'hFFFF_FFFF);
		push_req(REQ_RECORD, 16'd7, 32'hFFFF_FFFF);
		push_req(REQ_SCAN, 16'd0, 32'd2);
		push_req(REQ_CLEAR, 16'd0, 32'd2);
		push_req(REQ_CLEAR, 16'd64, 32'd2);
		push_req(REQ_QUERY, 16'd7, 32'd2);
		push_req(REQ_RECORD, 16'd7, 32'd5);
		push_req(REQ_QUERY, 16'd7, 32'd100);
		wait_drained();

		// random phases over several register settings
		for (int ph = 0; ph < 6; ph++) begin
			if (ph < 2) begin
				send_idle_pct = 28;
				recv_idle_pct = 67;
			end else if (ph < 4) begin
				send_idle_pct = 67;
				recv_idle_pct = 28;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			psize   = 6;
			n_items = 24;
			case (ph)
			0: begin
				rtt_pick  = 14'd10000;
				maxr_pick = 4'd1;
			end
			1: begin
				rtt_pick  = 14'd1;
				maxr_pick = 4'd15;
			end
			2: begin
				rtt_pick  = '1;
				maxr_pick = 4'd15;
			end
			3: begin
				// zero base: every live slot below max_retries is due at once
				rtt_pick  = '0;
				maxr_pick = 4'd15;
				psize     = 2;
				n_items   = 40;
			end
			4: begin
				// zero limit: every live slot is exhausted
				rtt_pick  = 14'd2;
				maxr_pick = '0;
			end
			default: begin
				rtt_pick  = RTT_W'($urandom_range(1, 10000));
				maxr_pick = RET_W'($urandom_range(1, 15));
			end
			endcase
			set_regs(rtt_pick, maxr_pick);
			gen_phase(n_items, psize, rtt_pick);
			wait_drained();
		end

		if (table_rsp_q.size() != 0) begin
			$error("%0d response beats never arrived", table_rsp_q.size());
			err_cnt++;
		end
		if (err_cnt == 0)
			$display("nack_retry_backoff_table_top regression: pass");
		else
			$display("nack_retry_backoff_table_top regression: fail");
		$finish;
	end

endmodule
